FILE: rtl/skvt_pkg.sv
// Shared widths, codes and record type of the sorted key/score table.
package skvt_pkg;

  localparam int OPC_W     = 3;
  localparam int KEY_W     = 32;
  localparam int SCORE_W   = 16;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 7;
  localparam int DEPTH_DEF = 64;
  localparam int REC_W     = KEY_W + SCORE_W;

  localparam logic [OPC_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OPC_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OPC_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OPC_W-1:0] OP_SEARCH = 3'd3;
  localparam logic [OPC_W-1:0] OP_LIST   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
  } rec_t;

endpackage

FILE: rtl/skvt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module skvt_ram #(
  parameter int WIDTH = skvt_pkg::REC_W,
  parameter int DEPTH = skvt_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/sorted_key_value_table_core.sv
// Sorted key/score table: records kept in ascending key order in one RAM.
// Up to DEPTH records (key, score in tenths) sit in a single RAM with one
// write and one read port and registered read data; insert, search, delete
// and list walk that RAM one entry at a time, one operation at a time, and
// the input stalls until the operation has handed its final result to the
// output register. Unused opcodes are dropped with no result. Insert moves
// the entries at or above its position up one; search scans up to the
// match, or over every record when there is none; delete scans to the
// match, then moves the rest down. List delivers one record per cycle while
// the output is not stalled, or one result for an empty table. Entries at or
// above the record count are never read.
module sorted_key_value_table_core
  #(
  parameter int DEPTH = skvt_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [skvt_pkg::OPC_W-1:0]    in_opcode,
  input  logic [skvt_pkg::KEY_W-1:0]    in_key,
  input  logic [skvt_pkg::SCORE_W-1:0]  in_score_tenths,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [skvt_pkg::STATUS_W-1:0] out_status,
  output logic [skvt_pkg::KEY_W-1:0]    out_key,
  output logic [skvt_pkg::SCORE_W-1:0]  out_score,
  output logic [skvt_pkg::COUNT_W-1:0]  out_entry_count,
  output logic                          out_last
);
  import skvt_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_CMP  = 3'd1;
  localparam logic [2:0] S_INS_HEAD = 3'd2;
  localparam logic [2:0] S_SCAN_CMP = 3'd3;
  localparam logic [2:0] S_DEL_WR   = 3'd4;
  localparam logic [2:0] S_LIST_OUT = 3'd5;
  localparam logic [2:0] S_RESP     = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic                is_delete_r, is_delete_nxt;
  rec_t                op_rec_r, op_rec_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  rec_t                res_rec_r, res_rec_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  rec_t                out_rec_r, out_rec_nxt;
  logic [CNT_W-1:0]    out_count_r, out_count_nxt;
  logic                out_last_r, out_last_nxt;

  logic                wr_en, rd_en;
  logic [IDX_W-1:0]    wr_addr, rd_addr;
  rec_t                wr_rec, rd_rec;
  logic [REC_W-1:0]    rd_data;

  logic [CNT_W:0]      cnt_x, idx_p1, idx_p2;
  logic [CNT_W-1:0]    idx_m1, idx_m2;
  logic                out_free;

  assign rd_rec   = rd_data;
  assign cnt_x    = {1'b0, count_r};
  assign idx_p1   = {1'b0, idx_r} + 1'b1;
  assign idx_p2   = {1'b0, idx_r} + 2'd2;
  assign idx_m1   = idx_r - 1'b1;
  assign idx_m2   = idx_r - 2'd2;
  assign out_free = !out_valid_r || !out_stall;

  skvt_ram #(
    .WIDTH(REC_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_rec),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    is_delete_nxt  = is_delete_r;
    op_rec_nxt     = op_rec_r;
    res_status_nxt = res_status_r;
    res_rec_nxt    = res_rec_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_rec_nxt    = out_rec_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_rec         = op_rec_r;
    rd_en          = 1'b0;
    rd_addr        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_rec_nxt    = '{key: in_key, score: in_score_tenths};
          is_delete_nxt = (in_opcode == OP_DELETE);
          res_rec_nxt   = '0;
          idx_nxt       = '0;
          unique case (in_opcode) inside
            OP_CLEAR: begin
              count_nxt      = '0;
              res_status_nxt = ST_OK;
              state_nxt      = S_RESP;
            end
            OP_INSERT: begin
              if (count_r == CNT_W'(DEPTH)) begin
                res_status_nxt = ST_FULL;
                state_nxt      = S_RESP;
              end else if (count_r == '0) begin
                wr_en          = 1'b1;
                wr_addr        = '0;
                wr_rec         = '{key: in_key, score: in_score_tenths};
                count_nxt      = count_r + 1'b1;
                res_status_nxt = ST_OK;
                state_nxt      = S_RESP;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = IDX_W'(count_r - 1'b1);
                idx_nxt   = count_r;
                state_nxt = S_INS_CMP;
              end
            end
            OP_DELETE, OP_SEARCH: begin
              if (count_r == '0) begin
                res_status_nxt = ST_NOT_FOUND;
                state_nxt      = S_RESP;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = S_SCAN_CMP;
              end
            end
            OP_LIST: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_RESP;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = S_LIST_OUT;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_INS_CMP: begin
        wr_en   = 1'b1;
        wr_addr = idx_r[IDX_W-1:0];
        if (rd_rec.key < op_rec_r.key) begin
          wr_rec         = op_rec_r;
          count_nxt      = count_r + 1'b1;
          res_status_nxt = ST_OK;
          state_nxt      = S_RESP;
        end else begin
          wr_rec  = rd_rec;
          idx_nxt = idx_m1;
          if (idx_m1 == '0) begin
            state_nxt = S_INS_HEAD;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_m2[IDX_W-1:0];
          end
        end
      end

      S_INS_HEAD: begin
        wr_en          = 1'b1;
        wr_addr        = '0;
        wr_rec         = op_rec_r;
        count_nxt      = count_r + 1'b1;
        res_status_nxt = ST_OK;
        state_nxt      = S_RESP;
      end

      S_SCAN_CMP: begin
        if (rd_rec.key == op_rec_r.key) begin
          res_status_nxt = ST_OK;
          if (!is_delete_r) begin
            res_rec_nxt = rd_rec;
            state_nxt   = S_RESP;
          end else if (idx_p1 < cnt_x) begin
            rd_en     = 1'b1;
            rd_addr   = idx_p1[IDX_W-1:0];
            state_nxt = S_DEL_WR;
          end else begin
            count_nxt = count_r - 1'b1;
            state_nxt = S_RESP;
          end
        end else if (idx_p1 < cnt_x) begin
          rd_en   = 1'b1;
          rd_addr = idx_p1[IDX_W-1:0];
          idx_nxt = idx_p1[CNT_W-1:0];
        end else begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_RESP;
        end
      end

      S_DEL_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_r[IDX_W-1:0];
        wr_rec  = rd_rec;
        idx_nxt = idx_p1[CNT_W-1:0];
        if (idx_p2 < cnt_x) begin
          rd_en   = 1'b1;
          rd_addr = idx_p2[IDX_W-1:0];
        end else begin
          count_nxt      = count_r - 1'b1;
          res_status_nxt = ST_OK;
          state_nxt      = S_RESP;
        end
      end

      S_LIST_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_rec_nxt    = rd_rec;
          out_count_nxt  = count_r;
          out_last_nxt   = (idx_p1 == cnt_x);
          idx_nxt        = idx_p1[CNT_W-1:0];
          if (idx_p1 < cnt_x) begin
            rd_en   = 1'b1;
            rd_addr = idx_p1[IDX_W-1:0];
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_rec_nxt    = res_rec_r;
          out_count_nxt  = count_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    is_delete_r  <= is_delete_nxt;
    op_rec_r     <= op_rec_nxt;
    res_status_r <= res_status_nxt;
    res_rec_r    <= res_rec_nxt;
    out_status_r <= out_status_nxt;
    out_rec_r    <= out_rec_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_key         = out_rec_r.key;
  assign out_score       = out_rec_r.score;
  assign out_entry_count = COUNT_W'(out_count_r);
  assign out_last        = out_last_r;

endmodule

FILE: tb/sorted_key_value_table_core_tb.sv
// Self-checking testbench for the sorted key/score table: queued driver, scoreboard, watchdog.
module sorted_key_value_table_core_tb;
  import skvt_pkg::*;

  localparam int DEPTH          = DEPTH_DEF;
  localparam int ITEMS          = 380;
  localparam int TAIL_ITEMS     = 40;
  localparam int SETTLE_CYCLES  = 4 * DEPTH + 20;
  localparam int WATCHDOG_LIMIT = 20 * DEPTH + 200;
  localparam int MAX_REPORTS    = 50;

  localparam logic [OPC_W-1:0] OP_RSVD0 = 3'd5;
  localparam logic [OPC_W-1:0] OP_RSVD1 = 3'd6;
  localparam logic [OPC_W-1:0] OP_RSVD2 = 3'd7;

  typedef struct {
    logic [OPC_W-1:0]   opcode;
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
    bit                 drain;
  } table_op_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key;
    logic [SCORE_W-1:0]  score;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } table_reply_t;

  logic                clk             = 1'b0;
  logic                rst_n           = 1'b0;
  logic                in_valid        = 1'b0;
  logic                in_stall;
  logic [OPC_W-1:0]    in_opcode       = '0;
  logic [KEY_W-1:0]    in_key          = '0;
  logic [SCORE_W-1:0]  in_score_tenths = '0;
  logic                out_valid;
  logic                out_stall       = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [KEY_W-1:0]    out_key;
  logic [SCORE_W-1:0]  out_score;
  logic [COUNT_W-1:0]  out_entry_count;
  logic                out_last;

  table_op_t    op_q[$];
  table_reply_t reply_q[$];
  int           op_counted  = 0;
  int           err_count   = 0;
  int           quiet_count = 0;
  int           in_gap      = 0;
  int           stall_gap   = 0;
  logic         in_taken    = 1'b0;
  logic         noisy       = 1'b1;

  logic [KEY_W-1:0]   tbl_key[DEPTH];
  logic [SCORE_W-1:0] tbl_score[DEPTH];
  int                 tbl_count = 0;

  sorted_key_value_table_core #(.DEPTH(DEPTH)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_key          (in_key),
    .in_score_tenths (in_score_tenths),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_key         (out_key),
    .out_score       (out_score),
    .out_entry_count (out_entry_count),
    .out_last        (out_last)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [KEY_W-1:0] want,
                                 input logic [KEY_W-1:0] got);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $time);
    end
  endtask

  task automatic push_reply(input logic [STATUS_W-1:0] status, input logic [KEY_W-1:0] key,
                            input logic [SCORE_W-1:0] score, input logic last);
    table_reply_t r;
    r.status = status;
    r.key    = key;
    r.score  = score;
    r.count  = COUNT_W'(tbl_count);
    r.last   = last;
    reply_q.push_back(r);
  endtask

  task automatic table_apply(input logic [OPC_W-1:0] opcode, input logic [KEY_W-1:0] key,
                             input logic [SCORE_W-1:0] score);
    int pos;
    int i;
    pos = 0;
    case (opcode)
      OP_CLEAR: begin
        tbl_count = 0;
        push_reply(ST_OK, '0, '0, 1'b1);
      end
      OP_INSERT: begin
        if (tbl_count >= DEPTH) begin
          push_reply(ST_FULL, '0, '0, 1'b1);
        end else begin
          while (pos < tbl_count && tbl_key[pos] < key) pos++;
          for (i = tbl_count; i > pos; i--) begin
            tbl_key[i]   = tbl_key[i-1];
            tbl_score[i] = tbl_score[i-1];
          end
          tbl_key[pos]   = key;
          tbl_score[pos] = score;
          tbl_count++;
          push_reply(ST_OK, '0, '0, 1'b1);
        end
      end
      OP_DELETE: begin
        while (pos < tbl_count && tbl_key[pos] != key) pos++;
        if (pos >= tbl_count) begin
          push_reply(ST_NOT_FOUND, '0, '0, 1'b1);
        end else begin
          for (i = pos; i + 1 < tbl_count; i++) begin
            tbl_key[i]   = tbl_key[i+1];
            tbl_score[i] = tbl_score[i+1];
          end
          tbl_count--;
          push_reply(ST_OK, '0, '0, 1'b1);
        end
      end
      OP_SEARCH: begin
        while (pos < tbl_count && tbl_key[pos] != key) pos++;
        if (pos >= tbl_count) begin
          push_reply(ST_NOT_FOUND, '0, '0, 1'b1);
        end else begin
          push_reply(ST_OK, tbl_key[pos], tbl_score[pos], 1'b1);
        end
      end
      OP_LIST: begin
        if (tbl_count == 0) begin
          push_reply(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (i = 0; i < tbl_count; i++) begin
            push_reply(ST_OK, tbl_key[i], tbl_score[i], i == tbl_count - 1);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic add_op(input logic [OPC_W-1:0] opcode, input logic [KEY_W-1:0] key,
                        input logic [SCORE_W-1:0] score, input bit drain);
    table_op_t t;
    t.opcode = opcode;
    t.key    = key;
    t.score  = score;
    t.drain  = drain;
    op_q.push_back(t);
    if (opcode <= OP_LIST) op_counted++;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return KEY_W'($urandom_range(0, 23));
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return '1;
        2:       return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [SCORE_W-1:0] pick_score();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return SCORE_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [OPC_W-1:0] pick_unused();
    case ($urandom_range(0, 2))
      0:       return OP_RSVD0;
      1:       return OP_RSVD1;
      default: return OP_RSVD2;
    endcase
  endfunction

  task automatic build_stimulus();
    int unsigned r;
    int i;
    logic [OPC_W-1:0] op;
    add_op(OP_LIST,   '0,            '0,            1'b0);
    add_op(OP_SEARCH, 32'd5,         '0,            1'b0);
    add_op(OP_DELETE, 32'd5,         '0,            1'b0);
    add_op(OP_INSERT, '0,            '0,            1'b0);
    add_op(OP_INSERT, '1,            '1,            1'b0);
    add_op(OP_INSERT, 32'd100,       16'd123,       1'b0);
    add_op(OP_INSERT, 32'd100,       16'd7,         1'b0);
    add_op(OP_INSERT, '0,            16'd1,         1'b0);
    add_op(OP_SEARCH, 32'd100,       '0,            1'b0);
    add_op(OP_SEARCH, '0,            '0,            1'b0);
    add_op(OP_SEARCH, '1,            '0,            1'b0);
    add_op(OP_SEARCH, 32'd55,        '0,            1'b0);
    add_op(OP_LIST,   '0,            '0,            1'b1);
    add_op(OP_DELETE, 32'd100,       '0,            1'b0);
    add_op(OP_DELETE, 32'd100,       '0,            1'b0);
    add_op(OP_DELETE, 32'd100,       '0,            1'b0);
    add_op(OP_RSVD0,  $urandom(),    pick_score(),  1'b0);
    add_op(OP_RSVD1,  $urandom(),    pick_score(),  1'b0);
    add_op(OP_RSVD2,  $urandom(),    pick_score(),  1'b0);
    add_op(OP_DELETE, '1,            '0,            1'b0);
    add_op(OP_LIST,   '0,            '0,            1'b0);
    add_op(OP_CLEAR,  $urandom(),    pick_score(),  1'b0);
    add_op(OP_LIST,   '0,            '0,            1'b1);
    add_op(OP_INSERT, 32'hAAAA_AAAA, 16'h5555,      1'b0);
    add_op(OP_INSERT, 32'h5555_5555, 16'hAAAA,      1'b0);

    // fill past capacity, then walk the full table
    add_op(OP_CLEAR, '0, '0, 1'b0);
    for (i = 0; i < DEPTH + 2; i++) add_op(OP_INSERT, pick_key(), pick_score(), 1'b0);
    add_op(OP_LIST,   '0,         '0, 1'b1);
    add_op(OP_SEARCH, pick_key(), '0, 1'b0);
    add_op(OP_SEARCH, pick_key(), '0, 1'b0);
    add_op(OP_DELETE, pick_key(), '0, 1'b0);
    add_op(OP_DELETE, pick_key(), '0, 1'b0);
    add_op(OP_INSERT, pick_key(), pick_score(), 1'b0);
    add_op(OP_LIST,   '0,         '0, 1'b0);

    while (op_counted < ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 38)      op = OP_INSERT;
      else if (r < 58) op = OP_DELETE;
      else if (r < 87) op = OP_SEARCH;
      else if (r < 96) op = OP_LIST;
      else if (r < 97) op = OP_CLEAR;
      else             op = pick_unused();
      add_op(op, pick_key(), pick_score(), $urandom_range(0, 49) == 0);
    end
  endtask

  always @(negedge clk) begin : drive
    logic      nxt_valid;
    table_op_t t;
    nxt_valid = in_valid;
    if (in_valid && in_taken) nxt_valid = 1'b0;
    if (rst_n && !nxt_valid) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (op_q.size() > 0 && !(op_q[0].drain && reply_q.size() != 0)) begin
        if (noisy && op_q.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(1, 10) - 1;
        end else begin
          t = op_q.pop_front();
          nxt_valid = 1'b1;
          in_opcode       <= t.opcode;
          in_key          <= t.key;
          in_score_tenths <= t.score;
        end
      end
    end
    in_valid <= nxt_valid;
  end

  always @(negedge clk) begin : backpressure
    logic nxt_stall;
    nxt_stall = 1'b0;
    if (stall_gap > 0) begin
      stall_gap--;
      nxt_stall = 1'b1;
    end else if (noisy && op_q.size() > TAIL_ITEMS && $urandom_range(0, 6) == 0) begin
      stall_gap = $urandom_range(1, 10) - 1;
      nxt_stall = 1'b1;
    end
    out_stall <= nxt_stall;
  end

  always @(posedge clk) begin : scoreboard
    table_reply_t e;
    logic         in_xfer;
    logic         out_xfer;
    in_xfer  = rst_n && in_valid && in_stall === 1'b0;
    out_xfer = rst_n && out_valid === 1'b1 && !out_stall;
    in_taken <= in_xfer;
    if ($urandom_range(0, 99) == 0) noisy <= !noisy;
    if (out_xfer) begin
      if (reply_q.size() == 0) begin
        report_mismatch("transfer with no reply outstanding", '0, out_key);
      end else begin
        e = reply_q.pop_front();
        if (out_status !== e.status) report_mismatch("status", e.status, out_status);
        if (out_key !== e.key) report_mismatch("key", e.key, out_key);
        if (out_score !== e.score) report_mismatch("score", e.score, out_score);
        if (out_entry_count !== e.count) report_mismatch("entry_count", e.count, out_entry_count);
        if (out_last !== e.last) report_mismatch("last", e.last, out_last);
      end
    end
    if (in_xfer) table_apply(in_opcode, in_key, in_score_tenths);
    if (!rst_n || in_xfer || out_xfer) quiet_count <= 0;
    else quiet_count <= quiet_count + 1;
    if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", quiet_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    while (op_q.size() != 0 || in_valid || reply_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (reply_q.size() != 0) report_mismatch("replies never delivered", '0, reply_q.size());
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/skvt_pkg.sv
rtl/skvt_ram.sv
rtl/sorted_key_value_table_core.sv
tb/sorted_key_value_table_core_tb.sv
